[src/cvms_pkg.sv]
// cvms_pkg: shared types, constants and helpers for closest_video_mode_select
// no dependencies; imported by cvms_best and closest_video_mode_select
`timescale 1ns / 1ps
`default_nettype none

package cvms_pkg;

  // field widths
  localparam int unsigned NUM_W   = 8;
  localparam int unsigned DIM_W   = 12;
  localparam int unsigned BPP_W   = 3;
  localparam int unsigned BITS_W  = 6;
  localparam int unsigned GAP_W   = DIM_W + 1;
  localparam int unsigned CHOSE_W = NUM_W + 1;

  // stream packing
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 16;

  // search markers
  localparam logic [CHOSE_W-1:0] NO_MODE  = '1;
  localparam logic [GAP_W-1:0]   GAP_NONE = '1;

  // reset values of the request registers
  localparam logic [DIM_W-1:0]  WANTED_WIDTH_RST  = 12'd640;
  localparam logic [DIM_W-1:0]  WANTED_HEIGHT_RST = 12'd480;
  localparam logic [BITS_W-1:0] WANTED_DEPTH_RST  = 6'd8;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_WANTED_WIDTH  = 2'd0,
    CFG_WANTED_HEIGHT = 2'd1,
    CFG_WANTED_DEPTH  = 2'd2
  } cfg_idx_t;

  // one mode descriptor
  typedef struct packed {
    logic [NUM_W-1:0] number;
    logic             present;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [BPP_W-1:0] bpp;
    logic             last;
  } desc_t;

  // absolute distance of two dimensions
  function automatic logic [DIM_W-1:0] gap_of(input logic [DIM_W-1:0] a,
                                              input logic [DIM_W-1:0] b);
    gap_of = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

[src/closest_video_mode_select.sv]
// closest_video_mode_select: top level with descriptor stage and result register
// depends on cvms_pkg and cvms_best
`timescale 1ns / 1ps
`default_nettype none

// Scans a list of video mode descriptors and returns the mode closest to the
// requested width, height and depth. One descriptor beat is taken every clock
// unless a last beat waits. Each beat passes the input register, where the
// best-so-far register is compared and updated; a last beat then loads the
// result into the output register, which holds one result; while it is
// stalled, non-last beats still flow and only a last beat waits.
// Absent modes and modes with zero bytes per pixel are skipped; a list with no
// usable mode returns -1 (all ones). Request registers are written with
// cfg_we, cfg_index and cfg_data and apply to the beats taken after the write,
// also in the middle of a list; write them only while no beat is held in the
// input register.
module closest_video_mode_select (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // config write port
  input  wire logic                               cfg_we,
  input  wire logic [1:0]                         cfg_index,
  input  wire logic [cvms_pkg::DIM_W-1:0]         cfg_data,
  // descriptor input
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // in_tdata: mode_number[7:0], mode_present[8], mode_width[20:9],
  //           mode_height[32:21], bytes_per_pixel[35:33], zero pad[39:36]
  input  wire logic [cvms_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire logic                               in_tlast,
  // result output
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // out_tdata: chosen_mode[8:0], zero pad[15:9]
  output logic      [cvms_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import cvms_pkg::*;

  logic [DIM_W-1:0]   wanted_width_r, wanted_width_nxt;
  logic [DIM_W-1:0]   wanted_height_r, wanted_height_nxt;
  logic [BITS_W-1:0]  wanted_depth_r, wanted_depth_nxt;

  logic               s1_valid_r, s1_valid_nxt;
  desc_t              s1_desc_r, s1_desc_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CHOSE_W-1:0] out_chosen_r, out_chosen_nxt;

  logic               in_accept;
  logic               s1_adv;
  desc_t              in_desc;
  logic [CHOSE_W-1:0] chosen;

  // config register writes
  always_comb begin
    wanted_width_nxt  = wanted_width_r;
    wanted_height_nxt = wanted_height_r;
    wanted_depth_nxt  = wanted_depth_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_WANTED_WIDTH:  wanted_width_nxt  = cfg_data;
        CFG_WANTED_HEIGHT: wanted_height_nxt = cfg_data;
        CFG_WANTED_DEPTH:  wanted_depth_nxt  = cfg_data[BITS_W-1:0];
        default:           wanted_width_nxt  = wanted_width_r;
      endcase
    end
  end

  // unpack the input beat
  always_comb begin
    in_desc.number  = in_tdata[7:0];
    in_desc.present = in_tdata[8];
    in_desc.width   = in_tdata[20:9];
    in_desc.height  = in_tdata[32:21];
    in_desc.bpp     = in_tdata[35:33];
    in_desc.last    = in_tlast;
  end

  // handshake: a last beat leaves only when the result register has room
  assign s1_adv    = s1_valid_r && (!s1_desc_r.last || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_accept = in_tvalid && in_tready;

  // input stage
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_desc_nxt  = s1_desc_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
      s1_desc_nxt  = in_desc;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // compare and keep the best mode
  cvms_best u_best (
    .clk           (clk),
    .rst_n         (rst_n),
    .upd           (s1_adv),
    .cand          (s1_desc_r),
    .wanted_width  (wanted_width_r),
    .wanted_height (wanted_height_r),
    .wanted_depth  (wanted_depth_r),
    .chosen        (chosen)
  );

  // result register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_chosen_nxt = out_chosen_r;
    if (s1_adv && s1_desc_r.last) begin
      out_valid_nxt  = 1'b1;
      out_chosen_nxt = chosen;
    end else if (out_tready) begin
      out_valid_nxt  = 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - CHOSE_W){1'b0}}, out_chosen_r};

  // control and config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_width_r  <= WANTED_WIDTH_RST;
      wanted_height_r <= WANTED_HEIGHT_RST;
      wanted_depth_r  <= WANTED_DEPTH_RST;
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      wanted_width_r  <= wanted_width_nxt;
      wanted_height_r <= wanted_height_nxt;
      wanted_depth_r  <= wanted_depth_nxt;
      s1_valid_r      <= s1_valid_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    s1_desc_r    <= s1_desc_nxt;
    out_chosen_r <= out_chosen_nxt;
  end

  // reset empties both stages
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !s1_valid_r && !out_valid_r)
    else $error("pipeline not empty after reset");

  // a new result only follows a last beat leaving the input stage
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv && s1_desc_r.last))
    else $error("result without last descriptor");

  // a last beat never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !(s1_adv && s1_desc_r.last))
    else $error("stalled result overwritten");

endmodule

`default_nettype wire

[src/cvms_best.sv]
// cvms_best: best-so-far mode register with the candidate compare
// depends on cvms_pkg
`timescale 1ns / 1ps
`default_nettype none

module cvms_best (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          upd,
  input  wire cvms_pkg::desc_t               cand,
  input  wire logic [cvms_pkg::DIM_W-1:0]    wanted_width,
  input  wire logic [cvms_pkg::DIM_W-1:0]    wanted_height,
  input  wire logic [cvms_pkg::BITS_W-1:0]   wanted_depth,
  output logic      [cvms_pkg::CHOSE_W-1:0]  chosen
);
  import cvms_pkg::*;

  logic [CHOSE_W-1:0] best_number_r, best_number_nxt;
  logic [GAP_W-1:0]   best_wgap_r, best_wgap_nxt;
  logic [GAP_W-1:0]   best_hgap_r, best_hgap_nxt;
  logic [BITS_W-1:0]  best_bits_r, best_bits_nxt;

  logic               qualify;
  logic [GAP_W-1:0]   wgap;
  logic [GAP_W-1:0]   hgap;
  logic [BITS_W-1:0]  bits;
  logic               take;

  // candidate distances and depth
  always_comb begin
    qualify = cand.present && (cand.bpp != '0);
    wgap    = {1'b0, gap_of(cand.width, wanted_width)};
    hgap    = {1'b0, gap_of(cand.height, wanted_height)};
    bits    = {cand.bpp, 3'b000};
  end

  // width first, then height, then depth on a full tie
  always_comb begin
    priority if (wgap < best_wgap_r) begin
      take = 1'b1;
    end else if (wgap > best_wgap_r) begin
      take = 1'b0;
    end else if (hgap < best_hgap_r) begin
      take = 1'b1;
    end else if (hgap > best_hgap_r) begin
      take = 1'b0;
    end else begin
      take = (bits >= best_bits_r) && (bits <= wanted_depth);
    end
  end

  // mode number after this descriptor is judged
  assign chosen = (qualify && take) ? {1'b0, cand.number} : best_number_r;

  // next best state, cleared at the end of a list
  always_comb begin
    best_number_nxt = best_number_r;
    best_wgap_nxt   = best_wgap_r;
    best_hgap_nxt   = best_hgap_r;
    best_bits_nxt   = best_bits_r;
    if (upd) begin
      if (cand.last) begin
        best_number_nxt = NO_MODE;
        best_wgap_nxt   = GAP_NONE;
        best_hgap_nxt   = GAP_NONE;
        best_bits_nxt   = '0;
      end else if (qualify && take) begin
        best_number_nxt = {1'b0, cand.number};
        best_wgap_nxt   = wgap;
        best_hgap_nxt   = hgap;
        best_bits_nxt   = bits;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_number_r <= NO_MODE;
      best_wgap_r   <= GAP_NONE;
      best_hgap_r   <= GAP_NONE;
      best_bits_r   <= '0;
    end else begin
      best_number_r <= best_number_nxt;
      best_wgap_r   <= best_wgap_nxt;
      best_hgap_r   <= best_hgap_nxt;
      best_bits_r   <= best_bits_nxt;
    end
  end

  // a closed list leaves no mode behind
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    upd && cand.last |=> best_number_r == NO_MODE && best_wgap_r == GAP_NONE)
    else $error("best state not cleared after last descriptor");

  // a held mode always carries real width and height distances
  a_gap_with_mode: assert property (@(posedge clk) disable iff (!rst_n)
    best_number_r != NO_MODE |-> best_wgap_r != GAP_NONE && best_hgap_r != GAP_NONE)
    else $error("best mode held without distances");

endmodule

`default_nettype wire
